### sv/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg: shared types and constants for the indexed min-heap queue.
// Holds the operation and status codes and the slot entry type.
// ----------------------------------------------------------------------------
package imhq_pkg;

    localparam int ID_W  = 6;
    localparam int PRI_W = 32;
    localparam int ID_SPACE = 64;
    localparam int ROOT_INDEX = 1;

    typedef enum logic [1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_EXTRACT  = 2'd1,
        FUNC_DECREASE = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [PRI_W-1:0] pri;
    } entry_t;

    // Signed compare: a strictly below b.
    function automatic logic pri_less(input logic signed [PRI_W-1:0] a,
                                      input logic signed [PRI_W-1:0] b);
        pri_less = (a < b);
    endfunction

endpackage

### sv/indexed_min_heap_queue.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue: indexed binary min-heap with decrease-key.
// Sequencer plus priority comparators that walk the heap level by level.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one item made of func,
// id and priority_req. Func selects insert, extract minimum or decrease
// priority. Every item produces exactly one result item on the output channel
// (out_valid/out_ready) with the status, the removed entry for an extract,
// the entry count and the current minimum.
// Sequence: an item is accepted in IDLE and checked in CHECK; then the sift
// loop runs on the slot memory (one read and one write port) and the
// priority comparators. A sift-up level passes ROOT_WR, DN_CMP, DN_CMP2,
// WR_A and WR_B; a sift-down level reads and compares both children before
// its two writes and the step to the next level. A rejected or unused
// operation goes through ROOT_RD and DONE to raise out_valid. in_ready
// returns the cycle after the result is loaded, so no new item is accepted
// before then. One item is processed at a time.
// The result sits in an output register; the next item may be accepted while
// that result still waits, but it holds in its final state until the receiver
// has taken the earlier result.
// Reset: count returns to zero and every id is marked absent through a
// valid bit per id; the slot memory is left undefined and only data from
// occupied slots is ever used.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue
    import imhq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              func,
    input  logic [ID_W-1:0]         id,
    input  logic signed [PRI_W-1:0] priority_req,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic [ID_W-1:0]         taken_id,
    output logic signed [PRI_W-1:0] taken_priority,
    output logic [$clog2(CAPACITY+1)-1:0] entry_count,
    output logic                    min_valid,
    output logic [ID_W-1:0]         min_id,
    output logic signed [PRI_W-1:0] min_priority
);

    localparam int SW = $clog2(CAPACITY+1);   // slot index / count width

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RD_A, S_RD_B, S_UP_CMP, S_DN_CMP, S_DN_CMP2,
        S_WR_A, S_WR_B, S_ROOT_WR, S_ROOT_RD, S_DONE
    } state_t;

    // Slot memory, index 0 unused.
    entry_t mem [CAPACITY+1];
    // Position map memory with a valid bit per id held in flip-flops.
    logic [SW-1:0] pos_mem [ID_SPACE];
    logic [SW-1:0] pos_rd_reg;
    logic [ID_SPACE-1:0] pos_vld_reg;

    state_t state_reg;
    logic [SW-1:0] count_reg;
    logic [1:0] func_reg;
    logic [ID_W-1:0] id_reg;
    logic signed [PRI_W-1:0] pri_reg;
    logic [SW-1:0] cur_reg, oth_reg, best_reg;
    entry_t cur_e_reg, oth_e_reg, rd_reg;
    logic go_up_reg;
    logic [1:0] st_reg;
    entry_t tk_reg;

    // Memory read port, one address a cycle, registered data.
    logic [SW-1:0] rd_addr;
    // Memory write port.
    logic mem_we;
    logic [SW-1:0] wr_addr;
    entry_t wr_data;
    // Position map write port.
    logic pos_we;
    logic [ID_W-1:0] pos_waddr;
    logic [SW-1:0] pos_wdata;

    logic posv;
    assign posv = pos_vld_reg[id_reg];

    logic res_pending;
    logic res_load;
    assign in_ready = (state_reg == S_IDLE);
    assign res_load = (state_reg == S_DONE) && (!out_valid || out_ready);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // The map is read at the address on the id port, so the entry of an
    // accepted item is ready in the check cycle.
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rd_reg <= pos_mem[id];
    end

    always_comb
    begin
        rd_addr   = oth_reg;
        mem_we    = 1'b0;
        wr_addr   = cur_reg;
        wr_data   = cur_e_reg;
        pos_we    = 1'b0;
        pos_waddr = id_reg;
        pos_wdata = count_reg + 1'b1;
        unique case (state_reg)
            S_CHECK:
            begin
                pos_we = (func_reg == FUNC_INSERT) &&
                         !(count_reg >= SW'(CAPACITY) || posv);
            end
            S_UP_CMP:
            begin
                pos_we = (count_reg != SW'(1));
                pos_waddr = rd_reg.id; pos_wdata = SW'(ROOT_INDEX);
            end
            S_RD_A:   rd_addr = cur_reg;
            S_WR_A:
            begin
                mem_we = 1'b1; wr_addr = cur_reg; wr_data = oth_e_reg;
                pos_we = 1'b1; pos_waddr = oth_e_reg.id; pos_wdata = cur_reg;
            end
            S_WR_B:
            begin
                mem_we = 1'b1; wr_addr = oth_reg; wr_data = cur_e_reg;
                pos_we = 1'b1; pos_waddr = cur_e_reg.id; pos_wdata = oth_reg;
            end
            S_ROOT_WR:
            begin
                mem_we = 1'b1; wr_addr = cur_reg; wr_data = cur_e_reg;
            end
            S_ROOT_RD, S_DONE: rd_addr = SW'(ROOT_INDEX);
            default: ;
        endcase
    end

    // Sift-up comparator: the item being sifted up against its parent.
    logic up_lt;
    assign up_lt = pri_less(cur_e_reg.pri, rd_reg.pri);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pos_vld_reg <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg  <= func;
                        id_reg    <= id;
                        pri_reg   <= priority_req;
                        st_reg    <= ST_OK;
                        tk_reg    <= '0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    unique case (func_reg)
                        FUNC_INSERT:
                        begin
                            if (count_reg >= SW'(CAPACITY) || posv)
                            begin
                                st_reg <= ST_FULL; state_reg <= S_ROOT_RD;
                            end
                            else
                            begin
                                count_reg <= count_reg + 1'b1;
                                cur_reg <= count_reg + 1'b1;
                                cur_e_reg <= '{id: id_reg, pri: pri_reg};
                                pos_vld_reg[id_reg] <= 1'b1;
                                go_up_reg <= 1'b1;
                                state_reg <= S_ROOT_WR;
                            end
                        end
                        FUNC_EXTRACT:
                        begin
                            if (count_reg == '0)
                            begin
                                st_reg <= ST_EMPTY; state_reg <= S_ROOT_RD;
                            end
                            else
                            begin
                                oth_reg <= count_reg; state_reg <= S_RD_A;
                                cur_reg <= SW'(ROOT_INDEX);
                            end
                        end
                        FUNC_DECREASE:
                        begin
                            if (!posv)
                            begin
                                st_reg <= ST_REJECTED; state_reg <= S_ROOT_RD;
                            end
                            else
                            begin
                                cur_reg <= pos_rd_reg; state_reg <= S_RD_A;
                            end
                        end
                        default: state_reg <= S_ROOT_RD;
                    endcase
                end
                S_RD_A:
                begin
                    // Read slot cur (root or decrease target); last via rd_b.
                    state_reg <= S_RD_B;
                end
                S_RD_B:
                begin
                    if (func_reg == FUNC_EXTRACT)
                    begin
                        // rd_reg holds root; next read gives last entry.
                        tk_reg <= rd_reg;
                        state_reg <= S_UP_CMP;
                    end
                    else
                    begin
                        // Decrease: rd_reg holds target slot.
                        if (!pri_less(pri_reg, rd_reg.pri))
                        begin
                            st_reg <= ST_REJECTED; state_reg <= S_ROOT_RD;
                        end
                        else
                        begin
                            cur_e_reg <= '{id: rd_reg.id, pri: pri_reg};
                            go_up_reg <= 1'b1;
                            state_reg <= S_ROOT_WR;
                        end
                    end
                end
                S_UP_CMP:
                begin
                    // Extract setup: rd_reg holds the last entry.
                    pos_vld_reg[tk_reg.id] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                    if (count_reg == SW'(1))
                    begin
                        state_reg <= S_ROOT_RD;
                    end
                    else
                    begin
                        cur_e_reg <= rd_reg;
                        go_up_reg <= 1'b0;
                        state_reg <= S_ROOT_WR;
                    end
                end
                S_ROOT_WR:
                begin
                    // cur_e written at cur; pick the next neighbor to test.
                    if (go_up_reg)
                    begin
                        if (cur_reg > SW'(ROOT_INDEX))
                        begin
                            oth_reg <= cur_reg >> 1;
                            state_reg <= S_DN_CMP;
                        end
                        else
                        begin
                            state_reg <= S_ROOT_RD;
                        end
                    end
                    else if ({cur_reg, 1'b0} <= {1'b0, count_reg})
                    begin
                        oth_reg <= SW'({cur_reg, 1'b0});
                        best_reg <= cur_reg;
                        state_reg <= S_DN_CMP;
                    end
                    else
                    begin
                        state_reg <= S_ROOT_RD;
                    end
                end
                S_DN_CMP:
                begin
                    // Memory read of oth in flight this cycle.
                    state_reg <= S_DN_CMP2;
                end
                S_DN_CMP2:
                begin
                    if (go_up_reg)
                    begin
                        if (up_lt)
                        begin
                            oth_e_reg <= rd_reg; state_reg <= S_WR_A;
                        end
                        else
                        begin
                            state_reg <= S_ROOT_RD;
                        end
                    end
                    else if (best_reg == cur_reg)
                    begin
                        // Left child read.
                        oth_e_reg <= rd_reg;
                        if ({1'b0, oth_reg} + 1'b1 <= {1'b0, count_reg})
                        begin
                            oth_reg <= oth_reg + 1'b1;
                            best_reg <= pri_less(rd_reg.pri, cur_e_reg.pri)
                                ? oth_reg : SW'(0);
                            state_reg <= S_DN_CMP;
                        end
                        else if (pri_less(rd_reg.pri, cur_e_reg.pri))
                        begin
                            state_reg <= S_WR_A;
                        end
                        else
                        begin
                            state_reg <= S_ROOT_RD;
                        end
                    end
                    else
                    begin
                        // Right child read; best_reg is left or 0 (= cur).
                        if (best_reg == '0)
                        begin
                            if (pri_less(rd_reg.pri, cur_e_reg.pri))
                            begin
                                oth_e_reg <= rd_reg; state_reg <= S_WR_A;
                            end
                            else
                            begin
                                state_reg <= S_ROOT_RD;
                            end
                        end
                        else if (pri_less(rd_reg.pri, oth_e_reg.pri))
                        begin
                            oth_e_reg <= rd_reg; state_reg <= S_WR_A;
                        end
                        else
                        begin
                            oth_reg <= best_reg; state_reg <= S_WR_A;
                        end
                    end
                end
                S_WR_A:
                begin
                    // Other entry moves into cur.
                    state_reg <= S_WR_B;
                end
                S_WR_B:
                begin
                    cur_reg <= oth_reg;
                    state_reg <= S_ROOT_WR;
                end
                S_ROOT_RD:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_load)
                    begin
                        status         <= st_reg;
                        taken_id       <= (st_reg == ST_OK &&
                                           func_reg == FUNC_EXTRACT) ? tk_reg.id : '0;
                        taken_priority <= (st_reg == ST_OK &&
                                           func_reg == FUNC_EXTRACT) ? tk_reg.pri : '0;
                        entry_count    <= count_reg;
                        min_valid      <= (count_reg != '0);
                        min_id         <= (count_reg != '0) ? rd_reg.id : '0;
                        min_priority   <= (count_reg != '0) ? rd_reg.pri : '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_pending = out_valid && !out_ready;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SW'(CAPACITY))
        else $error("count above capacity");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_pending |=> out_valid)
        else $error("result dropped");
    a_minvalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_valid == (entry_count != '0)))
        else $error("min_valid mismatch");
`endif

endmodule
